FILE: rtl/core/tpu_pkg.sv
// ----------------------------------------------------------------------------
// Texture pixel unpacker package
// Shared format codes, register indexes, pixel type and the 5-bit expansion
// table.
// ----------------------------------------------------------------------------
package tpu_pkg;

    localparam logic [1:0] FMT_RGBA8888 = 2'd0;
    localparam logic [1:0] FMT_RGBA5551 = 2'd1;
    localparam logic [1:0] FMT_ALPHA8   = 2'd2;
    localparam logic [1:0] FMT_UNUSED   = 2'd3;

    localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_ROW_ALIGNMENT = 2'd3;

    localparam logic [3:0] ALIGN_2 = 4'd2;
    localparam logic [3:0] ALIGN_4 = 4'd4;
    localparam logic [3:0] ALIGN_8 = 4'd8;

    localparam int CfgDataWidth = 11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    // floor(c * 255 / 31)
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage

FILE: rtl/core/tpu_byte_if.sv
// ----------------------------------------------------------------------------
// Byte stream interface
// Valid/ready channel carrying one byte of the client pixel buffer.
// ----------------------------------------------------------------------------
interface tpu_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);

endinterface

FILE: rtl/core/tpu_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one RGBA8888 pixel with row and image marks.
// ----------------------------------------------------------------------------
interface tpu_pixel_if;

    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;

    modport source (
        output valid, output red, output green, output blue, output alpha,
        output row_end, output image_end, input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input alpha,
        input row_end, input image_end, output ready
    );

endinterface

FILE: rtl/core/texture_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// Texture pixel unpacker
// Turns a client texture byte stream into RGBA8888 pixels in raster order.
// ----------------------------------------------------------------------------
// byte_stream takes one byte per transfer; pixel_stream gives one pixel with
// row_end and image_end marks. Formats: RGBA8888 (4 bytes), RGBA5551 little-
// endian (2 bytes), ALPHA8 (1 byte). Row padding up to row_alignment is
// dropped after every row but the last.
// A byte is held in an input register, then unpacked into the pixel register,
// which offers the pixel. One byte is taken every cycle while pixel_stream
// does not stall; a pixel leaves after every 4, 2 or 1 pixel bytes, set by the
// format. Registers are written through write_enable/reg_index/write_data;
// the user must write them only while no byte is in flight, which the block
// itself does not enforce. Each write restarts the image.
// Reset restores the register defaults (format RGBA8888, size 0x0,
// alignment 4) and clears all progress. While pixel_stream stalls, the
// pixel register holds and the input register takes one more byte, then
// byte_stream ready drops.
// ----------------------------------------------------------------------------
module texture_pixel_unpacker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [1:0]                          reg_index,
    input  logic [tpu_pkg::CfgDataWidth-1:0]    write_data,
    tpu_byte_if.sink                            byte_stream,
    tpu_pixel_if.source                         pixel_stream
);
    import tpu_pkg::*;

    logic [1:0]  pixel_format_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [3:0]  row_alignment_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [1:0]  byte_phase_reg, byte_phase_next;
    logic [23:0] held_bytes_reg, held_bytes_next;
    logic [10:0] column_count_reg, column_count_next;
    logic [10:0] row_count_reg, row_count_next;
    logic [2:0]  row_byte_offset_reg, row_byte_offset_next;
    logic        in_padding_reg, in_padding_next;

    logic        out_valid_reg, out_valid_next;
    pixel_t      pixel_reg;
    logic        row_end_reg, row_end_next;
    logic        image_end_reg, image_end_next;

    pixel_t      pixel;
    logic        advance;
    logic        emit;
    logic [2:0]  mask;
    logic [2:0]  offset;
    logic [2:0]  bpp;
    logic [11:0] column_inc;
    logic [11:0] row_inc;

    assign advance = in_valid_reg && (!out_valid_reg || pixel_stream.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign offset = row_byte_offset_reg + 3'd1;
    assign column_inc = {1'b0, column_count_reg} + 12'd1;
    assign row_inc = {1'b0, row_count_reg} + 12'd1;

    always_comb
    begin
        case (row_alignment_reg)
            ALIGN_2: mask = 3'd1;
            ALIGN_4: mask = 3'd3;
            ALIGN_8: mask = 3'd7;
            default: mask = 3'd0;
        endcase
    end

    always_comb
    begin
        case (pixel_format_reg)
            FMT_RGBA8888: bpp = 3'd4;
            FMT_RGBA5551: bpp = 3'd2;
            default:      bpp = 3'd1;
        endcase
    end

    tpu_convert u_convert (
        .pixel_format (pixel_format_reg),
        .held_bytes   (held_bytes_reg),
        .last_byte    (in_byte_reg),
        .pixel        (pixel)
    );

    always_comb
    begin
        byte_phase_next      = byte_phase_reg;
        held_bytes_next      = held_bytes_reg;
        column_count_next    = column_count_reg;
        row_count_next       = row_count_reg;
        row_byte_offset_next = row_byte_offset_reg;
        in_padding_next      = in_padding_reg;
        emit                 = 1'b0;
        row_end_next         = 1'b0;
        image_end_next       = 1'b0;

        if (advance && pixel_format_reg != FMT_UNUSED && image_width_reg != 11'd0
            && image_height_reg != 11'd0)
        begin
            if (in_padding_reg)
            begin
                if ((offset & mask) == 3'd0)
                begin
                    in_padding_next      = 1'b0;
                    row_byte_offset_next = 3'd0;
                end
                else
                begin
                    row_byte_offset_next = offset;
                end
            end
            else if ({1'b0, byte_phase_reg} + 3'd1 < bpp)
            begin
                case (byte_phase_reg)
                    2'd0:    held_bytes_next[7:0]   = held_bytes_reg[7:0] | in_byte_reg;
                    2'd1:    held_bytes_next[15:8]  = held_bytes_reg[15:8] | in_byte_reg;
                    2'd2:    held_bytes_next[23:16] = held_bytes_reg[23:16] | in_byte_reg;
                    default: held_bytes_next        = held_bytes_reg;
                endcase
                byte_phase_next      = byte_phase_reg + 2'd1;
                row_byte_offset_next = offset;
            end
            else
            begin
                emit            = 1'b1;
                byte_phase_next = 2'd0;
                held_bytes_next = 24'd0;
                if (column_inc >= {1'b0, image_width_reg})
                begin
                    row_end_next      = 1'b1;
                    column_count_next = 11'd0;
                    if (row_inc >= {1'b0, image_height_reg})
                    begin
                        image_end_next       = 1'b1;
                        row_count_next       = 11'd0;
                        row_byte_offset_next = 3'd0;
                        in_padding_next      = 1'b0;
                    end
                    else
                    begin
                        row_count_next = row_inc[10:0];
                        if ((offset & mask) != 3'd0)
                        begin
                            row_byte_offset_next = offset;
                            in_padding_next      = 1'b1;
                        end
                        else
                        begin
                            row_byte_offset_next = 3'd0;
                        end
                    end
                end
                else
                begin
                    column_count_next    = column_inc[10:0];
                    row_byte_offset_next = offset;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= FMT_RGBA8888;
            image_width_reg   <= 11'd0;
            image_height_reg  <= 11'd0;
            row_alignment_reg <= ALIGN_4;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_PIXEL_FORMAT:  pixel_format_reg  <= write_data[1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= write_data[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= write_data[10:0];
                REG_ROW_ALIGNMENT: row_alignment_reg <= write_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg      <= 2'd0;
            held_bytes_reg      <= 24'd0;
            column_count_reg    <= 11'd0;
            row_count_reg       <= 11'd0;
            row_byte_offset_reg <= 3'd0;
            in_padding_reg      <= 1'b0;
        end
        else if (write_enable)
        begin
            byte_phase_reg      <= 2'd0;
            held_bytes_reg      <= 24'd0;
            column_count_reg    <= 11'd0;
            row_count_reg       <= 11'd0;
            row_byte_offset_reg <= 3'd0;
            in_padding_reg      <= 1'b0;
        end
        else
        begin
            byte_phase_reg      <= byte_phase_next;
            held_bytes_reg      <= held_bytes_next;
            column_count_reg    <= column_count_next;
            row_count_reg       <= row_count_next;
            row_byte_offset_reg <= row_byte_offset_next;
            in_padding_reg      <= in_padding_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_valid_reg <= byte_stream.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            in_byte_reg <= byte_stream.data_byte;
        end
        if (emit)
        begin
            pixel_reg     <= pixel;
            row_end_reg   <= row_end_next;
            image_end_reg <= image_end_next;
        end
    end

    assign pixel_stream.valid     = out_valid_reg;
    assign pixel_stream.red       = pixel_reg.red;
    assign pixel_stream.green     = pixel_reg.green;
    assign pixel_stream.blue      = pixel_reg.blue;
    assign pixel_stream.alpha     = pixel_reg.alpha;
    assign pixel_stream.row_end   = row_end_reg;
    assign pixel_stream.image_end = image_end_reg;

`ifndef ASSERT_OFF
    a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && image_end_reg |-> row_end_reg)
        else $error("image_end without row_end");

    a_padding_no_partial_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_padding_reg |-> byte_phase_reg == 2'd0)
        else $error("padding with a partial pixel held");

    a_padding_unaligned: assert property (@(posedge clk) disable iff (!rst_n)
        in_padding_reg |-> (row_byte_offset_reg & mask) != 3'd0)
        else $error("padding at an aligned offset");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg == 11'd0 || column_count_reg < image_width_reg)
        else $error("column count beyond width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg == 11'd0 || row_count_reg < image_height_reg)
        else $error("row count beyond height");
`endif

endmodule

FILE: rtl/core/tpu_convert.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Builds one RGBA8888 pixel from the held bytes and the final byte.
// ----------------------------------------------------------------------------
module tpu_convert (
    input  logic [1:0]      pixel_format,
    input  logic [23:0]     held_bytes,
    input  logic [7:0]      last_byte,
    output tpu_pkg::pixel_t pixel
);
    import tpu_pkg::*;

    logic [15:0] word;

    assign word = {last_byte, held_bytes[7:0]};

    always_comb
    begin
        unique case (pixel_format)
            FMT_RGBA8888:
            begin
                pixel.red   = held_bytes[7:0];
                pixel.green = held_bytes[15:8];
                pixel.blue  = held_bytes[23:16];
                pixel.alpha = last_byte;
            end
            FMT_RGBA5551:
            begin
                pixel.red   = EXPAND5_LUT[word[15:11]];
                pixel.green = EXPAND5_LUT[word[10:6]];
                pixel.blue  = EXPAND5_LUT[word[5:1]];
                pixel.alpha = word[0] ? 8'hFF : 8'h00;
            end
            default:
            begin
                pixel.red   = 8'h00;
                pixel.green = 8'h00;
                pixel.blue  = 8'h00;
                pixel.alpha = last_byte;
            end
        endcase
    end

endmodule

FILE: tb/unpack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture unpacker checker
// Watches the configuration port and both streams. Every byte transfer runs
// through a bit-true unpack predictor. Every pixel transfer is compared field
// by field with the oldest predicted pixel. The failure count and the number
// of pixels still expected go to the testbench top.
// ----------------------------------------------------------------------------
module unpack_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [1:0]                       reg_index,
    input  logic [tpu_pkg::CfgDataWidth-1:0] write_data,
    tpu_byte_if                              byte_mon,
    tpu_pixel_if                             pixel_mon,
    output int                               error_count,
    output int                               pending_pixels
);

    import tpu_pkg::*;

    typedef struct packed {
        pixel_t px;
        logic   row_end;
        logic   image_end;
    } pixel_rec_t;

    logic [1:0]  cfg_format;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [3:0]  cfg_align;

    logic [1:0]  phase;
    logic [23:0] held;
    logic [10:0] col_cnt;
    logic [10:0] row_cnt;
    logic [2:0]  row_off;
    logic        padding;

    pixel_rec_t  expected_pixels [$];
    int          errors = 0;
    int          pending = 0;

    assign error_count    = errors;
    assign pending_pixels = pending;

    function automatic logic [7:0] scale5(input logic [4:0] c);
        int v;
        v = int'(c) * 255 / 31;
        return v[7:0];
    endfunction

    task automatic restart_image();
        phase   = '0;
        held    = '0;
        col_cnt = '0;
        row_cnt = '0;
        row_off = '0;
        padding = 1'b0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [10:0] data);
        case (idx)
            REG_PIXEL_FORMAT:  cfg_format = data[1:0];
            REG_IMAGE_WIDTH:   cfg_width  = data;
            REG_IMAGE_HEIGHT:  cfg_height = data;
            REG_ROW_ALIGNMENT: cfg_align  = data[3:0];
            default: ;
        endcase
        restart_image();
    endtask

    task automatic unpack_byte(input logic [7:0] b, output bit produced,
                               output pixel_rec_t rec);
        logic [2:0]  pad_mask;
        logic [2:0]  next_off;
        logic [15:0] word;
        int          bpp;
        produced = 1'b0;
        rec      = '0;
        case (cfg_align)
            ALIGN_2: pad_mask = 3'd1;
            ALIGN_4: pad_mask = 3'd3;
            ALIGN_8: pad_mask = 3'd7;
            default: pad_mask = 3'd0;
        endcase
        next_off = row_off + 3'd1;
        if (cfg_format > FMT_ALPHA8 || cfg_width == '0 || cfg_height == '0)
            return;
        if (padding)
        begin
            row_off = next_off;
            if ((next_off & pad_mask) == '0)
            begin
                padding = 1'b0;
                row_off = '0;
            end
            return;
        end
        bpp = (cfg_format == FMT_RGBA8888) ? 4 : (cfg_format == FMT_RGBA5551) ? 2 : 1;
        if (int'(phase) + 1 < bpp)
        begin
            held    = held | (24'(b) << (8 * phase));
            phase   = phase + 2'd1;
            row_off = next_off;
            return;
        end
        case (cfg_format)
            FMT_RGBA8888:
            begin
                rec.px.red   = held[7:0];
                rec.px.green = held[15:8];
                rec.px.blue  = held[23:16];
                rec.px.alpha = b;
            end
            FMT_RGBA5551:
            begin
                word         = {b, held[7:0]};
                rec.px.red   = scale5(word[15:11]);
                rec.px.green = scale5(word[10:6]);
                rec.px.blue  = scale5(word[5:1]);
                rec.px.alpha = word[0] ? 8'hFF : 8'h00;
            end
            default:
            begin
                rec.px.alpha = b;
            end
        endcase
        phase    = '0;
        held     = '0;
        produced = 1'b1;
        if (int'(col_cnt) + 1 >= int'(cfg_width))
        begin
            rec.row_end = 1'b1;
            col_cnt     = '0;
            if (int'(row_cnt) + 1 >= int'(cfg_height))
            begin
                rec.image_end = 1'b1;
                restart_image();
            end
            else
            begin
                row_cnt = row_cnt + 11'd1;
                if ((next_off & pad_mask) != '0)
                begin
                    row_off = next_off;
                    padding = 1'b1;
                end
                else
                begin
                    row_off = '0;
                end
            end
        end
        else
        begin
            col_cnt = col_cnt + 11'd1;
            row_off = next_off;
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_rec_t want;
        pixel_rec_t next_pixel;
        bit         produced;
        if (!rst_n)
        begin
            cfg_format = FMT_RGBA8888;
            cfg_width  = '0;
            cfg_height = '0;
            cfg_align  = ALIGN_4;
            restart_image();
            expected_pixels.delete();
        end
        else
        begin
            if (write_enable)
                write_register(reg_index, write_data);
            if (pixel_mon.valid && pixel_mon.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("pixel %0h%0h%0h%0h with none expected",
                        pixel_mon.red, pixel_mon.green, pixel_mon.blue, pixel_mon.alpha));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", pixel_mon.red, want.px.red);
                    check_field("green", pixel_mon.green, want.px.green);
                    check_field("blue", pixel_mon.blue, want.px.blue);
                    check_field("alpha", pixel_mon.alpha, want.px.alpha);
                    check_field("row_end", 8'(pixel_mon.row_end), 8'(want.row_end));
                    check_field("image_end", 8'(pixel_mon.image_end),
                                8'(want.image_end));
                end
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                unpack_byte(byte_mon.data_byte, produced, next_pixel);
                if (produced)
                    expected_pixels.insert(expected_pixels.size(), next_pixel);
            end
        end
        pending = expected_pixels.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture pixel unpacker testbench
// Drives byte streams for all three formats, odd widths, every row alignment
// and the ignored cases (unused format, zero size), then random images with
// random stalls on both streams and one long output hold. The checker module
// predicts and compares; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import tpu_pkg::*;

    localparam int         TOTAL_BYTES   = 1650;
    localparam int         TAIL_BYTES    = 200;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         DRAIN_CYCLES  = 4;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 150;

    localparam logic [7:0] EDGE_BYTES [16] = '{
        8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F,
        8'h55, 8'hAA, 8'h3E, 8'h07, 8'hC1, 8'hF8, 8'h80, 8'h01
    };

    logic                    clk;
    logic                    rst_n;
    logic                    write_enable;
    logic [1:0]              reg_index;
    logic [CfgDataWidth-1:0] write_data;
    logic                    long_hold_req;
    logic                    tail_phase;
    int                      error_count;
    int                      pending_pixels;
    int                      cycle_count;
    int                      edge_idx;
    int                      tx_gap_rate;

    tpu_byte_if  byte_bus ();
    tpu_pixel_if pixel_bus ();

    texture_pixel_unpacker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .byte_stream  (byte_bus),
        .pixel_stream (pixel_bus)
    );

    unpack_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .byte_mon       (byte_bus),
        .pixel_mon      (pixel_bus),
        .error_count    (error_count),
        .pending_pixels (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // pixel side: short random stalls, one long hold on request
    initial
    begin : pixel_sink
        int  rx_cycle;
        int  rx_gap_rate;
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        rx_cycle    = 0;
        rx_gap_rate = 0;
        stall_left  = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        pixel_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_gap_rate = $urandom_range(0, 2);
            if (long_hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                pixel_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                pixel_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (!tail_phase && rx_gap_rate != 0 && $urandom_range(0, 7) < rx_gap_rate)
            begin
                pixel_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                pixel_bus.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_image(input logic [10:0] fmt_word, input logic [10:0] width,
                                 input logic [10:0] height, input logic [10:0] align_word);
        wait_drained();
        write_enable <= 1'b1;
        reg_index    <= REG_PIXEL_FORMAT;
        write_data   <= fmt_word;
        @(negedge clk);
        reg_index    <= REG_IMAGE_WIDTH;
        write_data   <= width;
        @(negedge clk);
        reg_index    <= REG_IMAGE_HEIGHT;
        write_data   <= height;
        @(negedge clk);
        reg_index    <= REG_ROW_ALIGNMENT;
        write_data   <= align_word;
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] value);
        if (!tail_phase && tx_gap_rate != 0 && $urandom_range(0, 7) < tx_gap_rate)
        begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= value;
        @(posedge clk);
        while (!byte_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pattern(input int count);
        repeat (count)
        begin
            send_byte(EDGE_BYTES[edge_idx]);
            edge_idx = (edge_idx + 1) % 16;
        end
        byte_bus.valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_byte(8'($urandom));
        byte_bus.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [1:0]  fmt;
        logic [10:0] width;
        logic [10:0] height;
        logic [3:0]  align;
        int          bpp;
        int          row_bytes;
        int          pad_unit;
        int          padded;
        int          image_bytes;
        int          count;
        int          byte_total;
        int          phase_idx;
        rst_n              = 1'b0;
        write_enable       = 1'b0;
        reg_index          = REG_PIXEL_FORMAT;
        write_data         = '0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = '0;
        long_hold_req      = 1'b0;
        tail_phase         = 1'b0;
        edge_idx           = 0;
        tx_gap_rate        = 0;
        byte_total         = 0;
        phase_idx          = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero width after reset: dropped
        send_pattern(2);
        program_image(11'(FMT_RGBA8888), 11'd2, 11'd2, 11'(ALIGN_4));
        send_pattern(16);
        program_image(11'(FMT_RGBA5551), 11'd3, 11'd2, 11'(ALIGN_8));
        send_pattern(14);
        tx_gap_rate = 2;
        program_image(11'(FMT_ALPHA8), 11'd3, 11'd2, 11'(ALIGN_2));
        send_pattern(7);
        program_image(11'(FMT_UNUSED), 11'd4, 11'd4, 11'(ALIGN_4));
        send_pattern(3);
        program_image(11'(FMT_ALPHA8), 11'd2, 11'd0, 11'd1);
        send_pattern(2);
        program_image(11'(FMT_ALPHA8), 11'd1, 11'd1, 11'd0);
        send_pattern(2);
        program_image(11'(FMT_RGBA8888), 11'd2047, 11'd2047, 11'(ALIGN_8));
        send_pattern(8);
        program_image(11'(FMT_RGBA5551), 11'd1024, 11'd1024, 11'd3);
        send_pattern(6);

        // fill the block while the pixel side holds off
        tx_gap_rate = 0;
        program_image(11'(FMT_ALPHA8), 11'd4, 11'd30, 11'd1);
        long_hold_req <= 1'b1;
        send_random(120);
        byte_total = 120;

        while (byte_total < TOTAL_BYTES)
        begin
            if (byte_total >= TOTAL_BYTES - TAIL_BYTES)
                tail_phase <= 1'b1;
            tx_gap_rate = $urandom_range(0, 2);
            if (phase_idx == 0 || $urandom_range(0, 4) != 0)
            begin
                fmt = ($urandom_range(0, 15) == 0) ? FMT_UNUSED : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0:       width = '0;
                    1:       width = 11'($urandom);
                    default: width = 11'($urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 9))
                    0:       height = '0;
                    1:       height = 11'($urandom);
                    default: height = 11'($urandom_range(1, 6));
                endcase
                if ($urandom_range(0, 9) < 8)
                    align = 4'(1 << $urandom_range(0, 3));
                else
                    align = 4'($urandom_range(0, 15));
                program_image({9'($urandom), fmt}, width, height, {7'($urandom), align});
            end
            phase_idx++;
            if (fmt == FMT_UNUSED || width == '0 || height == '0)
            begin
                send_random($urandom_range(1, 6));
            end
            else
            begin
                bpp = (fmt == FMT_RGBA8888) ? 4 : (fmt == FMT_RGBA5551) ? 2 : 1;
                row_bytes = bpp * int'(width);
                pad_unit = (align == ALIGN_2 || align == ALIGN_4 || align == ALIGN_8)
                           ? int'(align) : 1;
                padded = (row_bytes + pad_unit - 1) / pad_unit * pad_unit;
                image_bytes = padded * (int'(height) - 1) + row_bytes;
                if (image_bytes <= 160)
                    count = image_bytes * $urandom_range(1, 2);
                else
                    count = $urandom_range(8, 48);
                if ($urandom_range(0, 4) == 0)
                    count += $urandom_range(1, 3);
                send_random(count);
                byte_total += count;
            end
        end

        while (pending_pixels != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: texture_pixel_unpacker.f
rtl/core/tpu_pkg.sv
rtl/core/tpu_byte_if.sv
rtl/core/tpu_pixel_if.sv
rtl/core/tpu_convert.sv
rtl/core/texture_pixel_unpacker.sv
tb/unpack_checker.sv
tb/testbench.sv
